@@ hdl/rstg_pkg.sv @@
// Package for the raster sync timing generator: widths, types, codes and reset values.
`timescale 1ns / 1ps

package rstg_pkg;

  // Widths of the timing registers and of the position counters.
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned REG_IDX_W = 3;

  // Sync styles.
  localparam int unsigned STYLE_SEPARATE     = 0;
  localparam int unsigned STYLE_COMPOSITE_XOR = 1;
  localparam int unsigned STYLE_COMPOSITE_AND = 2;
  localparam int unsigned STYLE_PAL          = 3;
  localparam int unsigned STYLE_DISABLED     = 4;

  // Build-time defaults.
  localparam int unsigned SYNC_STYLE_DEF        = STYLE_SEPARATE;
  localparam bit          HSYNC_ACTIVE_HIGH_DEF = 1'b0;
  localparam bit          VSYNC_ACTIVE_HIGH_DEF = 1'b0;

  // Register indexes on the configuration port.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_H_SYNC    = 3'd0,
    REG_H_BACK    = 3'd1,
    REG_H_VISIBLE = 3'd2,
    REG_H_FRONT   = 3'd3,
    REG_V_SYNC    = 3'd4,
    REG_V_BACK    = 3'd5,
    REG_V_VISIBLE = 3'd6,
    REG_V_FRONT   = 3'd7
  } cfg_reg_e;

  // Reset values of the timing registers (640x480 style timing).
  localparam logic [LEN_W-1:0] H_SYNC_RST    = 11'd96;
  localparam logic [LEN_W-1:0] H_BACK_RST    = 11'd48;
  localparam logic [LEN_W-1:0] H_VISIBLE_RST = 11'd640;
  localparam logic [LEN_W-1:0] H_FRONT_RST   = 11'd16;
  localparam logic [LEN_W-1:0] V_SYNC_RST    = 11'd2;
  localparam logic [LEN_W-1:0] V_BACK_RST    = 11'd33;
  localparam logic [LEN_W-1:0] V_VISIBLE_RST = 11'd480;
  localparam logic [LEN_W-1:0] V_FRONT_RST   = 11'd10;

  typedef struct packed {
    logic [LEN_W-1:0] h_sync_len;
    logic [LEN_W-1:0] h_back_len;
    logic [LEN_W-1:0] h_visible_len;
    logic [LEN_W-1:0] h_front_len;
    logic [LEN_W-1:0] v_sync_len;
    logic [LEN_W-1:0] v_back_len;
    logic [LEN_W-1:0] v_visible_len;
    logic [LEN_W-1:0] v_front_len;
  } timing_cfg_t;

  typedef struct packed {
    logic red_bit;
    logic green_bit;
    logic blue_bit;
  } in_item_t;

  typedef struct packed {
    logic             stream_sync;
    logic             vsync_pin;
    logic             red_out;
    logic             green_out;
    logic             blue_out;
    logic             in_visible;
    logic [LEN_W-1:0] pixel_x;
    logic [LEN_W-1:0] pixel_y;
    logic             line_begin;
    logic             frame_begin;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
  } pos_t;

  // Contents of the input register: the pixel and where it sits in the raster.
  typedef struct packed {
    in_item_t pix;
    pos_t     pos;
  } stage_t;

endpackage

@@ hdl/raster_sync_timing_generator_top.sv @@
// Top level of the raster sync timing generator: request pipeline and result register.
`timescale 1ns / 1ps

// The block turns a stream of pixel-clock requests, each carrying one pixel's red,
// green and blue bits, into display timing. Every accepted input request yields
// exactly one result request with the stream sync bit, the separate vsync pin level,
// the colour gated to the visible area, the visible x and y coordinates and the
// line and frame start flags. Both channels use valid and stall: a request moves
// at a clock edge where valid is high and stall is low.
// The sync style and the sync polarities are fixed at build time; the eight timing
// lengths are written through the cfg_we_i / cfg_idx_i / cfg_data_i port and take
// effect for the next pixel accepted. Write them only while no request is in flight.
// Throughput is one pixel per clock while the output is not stalled. The input
// register captures the pixel and its raster position, and the result register
// then holds the decoded outputs. The input register can still fill while the
// result register is held by a stall on the output side; in_stall_o rises only
// when both stages are full. No request is dropped or repeated while stalled.
// Reset returns the raster position to the top left corner, loads the default
// 640x480 timing and empties both stages.

module raster_sync_timing_generator_top #(
  parameter int unsigned SYNC_STYLE        = rstg_pkg::SYNC_STYLE_DEF,
  parameter bit          HSYNC_ACTIVE_HIGH = rstg_pkg::HSYNC_ACTIVE_HIGH_DEF,
  parameter bit          VSYNC_ACTIVE_HIGH = rstg_pkg::VSYNC_ACTIVE_HIGH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rstg_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [rstg_pkg::LEN_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rstg_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rstg_pkg::out_item_t            out_data_o
);
  import rstg_pkg::*;

  timing_cfg_t cfg;
  pos_t        pos;
  stage_t      stage_q;
  out_item_t   res, res_q;
  logic        stage_valid_q, stage_valid_d;
  logic        out_valid_q, out_valid_d;
  logic        out_load, stage_load, in_acc;

  // The result register can take a new request when it is empty or being drained;
  // the input register can when it is empty or moving into the result register.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign stage_load = !stage_valid_q || out_load;
  assign in_acc     = in_valid_i && stage_load;
  assign in_stall_o = !stage_load;

  assign stage_valid_d = stage_load ? in_valid_i : stage_valid_q;
  assign out_valid_d   = out_load ? stage_valid_q : out_valid_q;

  rstg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The position advances when a pixel is accepted; the pixel keeps a snapshot
  // of the position it was accepted at.
  rstg_position u_position (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (in_acc),
    .cfg_i  (cfg),
    .pos_o  (pos)
  );

  rstg_decode #(
    .SYNC_STYLE        (SYNC_STYLE),
    .HSYNC_ACTIVE_HIGH (HSYNC_ACTIVE_HIGH),
    .VSYNC_ACTIVE_HIGH (VSYNC_ACTIVE_HIGH)
  ) u_decode (
    .stage_i (stage_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers carry no reset; their valid bits guard them.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stage_q.pix <= in_data_i;
      stage_q.pos <= pos;
    end
    if (out_load && stage_valid_q) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

`ifndef ASSERT_OFF
  a_frame_implies_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_begin |-> out_data_o.line_begin)
    else $error("frame start flagged off a line start");

  a_blank_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_visible |->
      !out_data_o.red_out && !out_data_o.green_out && !out_data_o.blue_out &&
      (out_data_o.pixel_x == '0) && (out_data_o.pixel_y == '0))
    else $error("colour or coordinates not blanked outside the visible area");

  a_pin_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (SYNC_STYLE != STYLE_SEPARATE) |->
      out_data_o.vsync_pin == !VSYNC_ACTIVE_HIGH)
    else $error("vsync pin driven active in a composite or disabled style");

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid_q && !out_load |=> stage_valid_q && $stable(stage_q))
    else $error("input register changed while the result register was blocked");
`endif

endmodule

@@ hdl/rstg_cfg.sv @@
// Timing register file of the raster sync timing generator.
`timescale 1ns / 1ps

module rstg_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rstg_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rstg_pkg::LEN_W-1:0]         cfg_data_i,
  output rstg_pkg::timing_cfg_t              cfg_o
);
  import rstg_pkg::*;

  timing_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_H_SYNC:    cfg_d.h_sync_len    = cfg_data_i;
        REG_H_BACK:    cfg_d.h_back_len    = cfg_data_i;
        REG_H_VISIBLE: cfg_d.h_visible_len = cfg_data_i;
        REG_H_FRONT:   cfg_d.h_front_len   = cfg_data_i;
        REG_V_SYNC:    cfg_d.v_sync_len    = cfg_data_i;
        REG_V_BACK:    cfg_d.v_back_len    = cfg_data_i;
        REG_V_VISIBLE: cfg_d.v_visible_len = cfg_data_i;
        REG_V_FRONT:   cfg_d.v_front_len   = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.h_sync_len    <= H_SYNC_RST;
      cfg_q.h_back_len    <= H_BACK_RST;
      cfg_q.h_visible_len <= H_VISIBLE_RST;
      cfg_q.h_front_len   <= H_FRONT_RST;
      cfg_q.v_sync_len    <= V_SYNC_RST;
      cfg_q.v_back_len    <= V_BACK_RST;
      cfg_q.v_visible_len <= V_VISIBLE_RST;
      cfg_q.v_front_len   <= V_FRONT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/rstg_position.sv @@
// Column and row counters that walk the raster, one step per accepted pixel.
`timescale 1ns / 1ps

module rstg_position (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  rstg_pkg::timing_cfg_t cfg_i,
  output rstg_pkg::pos_t        pos_o
);
  import rstg_pkg::*;

  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [CNT_W-1:0] col_inc, row_inc, h_total, v_total;
  logic             col_wrap;

  // Line and frame totals; four 11-bit lengths always fit in the counter width.
  assign h_total = CNT_W'(cfg_i.h_sync_len) + CNT_W'(cfg_i.h_back_len)
                 + CNT_W'(cfg_i.h_visible_len) + CNT_W'(cfg_i.h_front_len);
  assign v_total = CNT_W'(cfg_i.v_sync_len) + CNT_W'(cfg_i.v_back_len)
                 + CNT_W'(cfg_i.v_visible_len) + CNT_W'(cfg_i.v_front_len);

  assign col_inc  = col_q + CNT_W'(1);
  assign row_inc  = row_q + CNT_W'(1);
  // A counter left past a shrunk total also wraps, hence greater-or-equal.
  assign col_wrap = (col_inc >= h_total);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (adv_i) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = (row_inc >= v_total) ? '0 : row_inc;
      end else begin
        col_d = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_o.col = col_q;
  assign pos_o.row = row_q;

`ifndef ASSERT_OFF
  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(col_q) && $stable(row_q))
    else $error("position counters moved without an accepted pixel");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |=> (col_q == CNT_W'($past(col_q) + CNT_W'(1))) || (col_q == '0))
    else $error("column counter neither stepped by one nor wrapped");
`endif

endmodule

@@ hdl/rstg_decode.sv @@
// Decodes one raster position into sync levels, gated colour, coordinates and flags.
`timescale 1ns / 1ps

module rstg_decode #(
  parameter int unsigned SYNC_STYLE        = rstg_pkg::SYNC_STYLE_DEF,
  parameter bit          HSYNC_ACTIVE_HIGH = rstg_pkg::HSYNC_ACTIVE_HIGH_DEF,
  parameter bit          VSYNC_ACTIVE_HIGH = rstg_pkg::VSYNC_ACTIVE_HIGH_DEF
) (
  input  rstg_pkg::stage_t      stage_i,
  input  rstg_pkg::timing_cfg_t cfg_i,
  output rstg_pkg::out_item_t   res_o
);
  import rstg_pkg::*;

  logic [CNT_W-1:0] col, row;
  logic [CNT_W-1:0] h_start, h_end, v_start, v_end;
  logic [CNT_W-1:0] x_off, y_off;
  logic             hvis, vvis, vis, vline, hs, vs;

  assign col = stage_i.pos.col;
  assign row = stage_i.pos.row;

  assign h_start = CNT_W'(cfg_i.h_sync_len) + CNT_W'(cfg_i.h_back_len);
  assign h_end   = h_start + CNT_W'(cfg_i.h_visible_len);
  assign v_start = CNT_W'(cfg_i.v_sync_len) + CNT_W'(cfg_i.v_back_len);
  assign v_end   = v_start + CNT_W'(cfg_i.v_visible_len);

  assign hvis  = (col >= h_start) && (col < h_end);
  assign vvis  = (row >= v_start) && (row < v_end);
  assign vis   = hvis && vvis;
  assign vline = (row < CNT_W'(cfg_i.v_sync_len));

  assign hs = (col < CNT_W'(cfg_i.h_sync_len)) ? HSYNC_ACTIVE_HIGH : !HSYNC_ACTIVE_HIGH;
  assign vs = vline ? VSYNC_ACTIVE_HIGH : !VSYNC_ACTIVE_HIGH;

  assign x_off = col - h_start;
  assign y_off = row - v_start;

  always_comb begin
    res_o.vsync_pin = !VSYNC_ACTIVE_HIGH;
    case (SYNC_STYLE)
      STYLE_SEPARATE: begin
        res_o.stream_sync = hs;
        res_o.vsync_pin   = vs;
      end
      STYLE_COMPOSITE_XOR: res_o.stream_sync = hs ^ vs;
      STYLE_COMPOSITE_AND: res_o.stream_sync = hs & vs;
      // Whole vsync lines carry the vsync level, other lines carry hsync.
      STYLE_PAL:           res_o.stream_sync = vline ? VSYNC_ACTIVE_HIGH : hs;
      default:             res_o.stream_sync = 1'b0;
    endcase

    res_o.red_out     = vis & stage_i.pix.red_bit;
    res_o.green_out   = vis & stage_i.pix.green_bit;
    res_o.blue_out    = vis & stage_i.pix.blue_bit;
    res_o.in_visible  = vis;
    res_o.pixel_x     = vis ? x_off[LEN_W-1:0] : '0;
    res_o.pixel_y     = vis ? y_off[LEN_W-1:0] : '0;
    res_o.line_begin  = (col == '0);
    res_o.frame_begin = (col == '0) && (row == '0);
  end

endmodule

@@ verif/testbench.sv @@
// Testbench for the raster sync timing generator: random pixel requests checked against a predictor.
`timescale 1ns / 1ps

// The testbench sends pixel requests into the block and checks every result request
// against a predictor. The predictor walks the raster by itself, so it has its own
// column and row counters and its own copy of the eight timing lengths.
//
// The run goes through several timing settings. Each setting is written only while
// the block is idle, after every expected result has arrived:
//   - the reset timing, for a few pixels at the top left corner;
//   - a tiny raster where the visible area comes early, so the colour gating and the
//     coordinates show up within the first directed pixels;
//   - porches of zero length, and then every length zero (a raster with no pixels,
//     where every tick is the first pixel of a frame);
//   - every length at its largest value;
//   - a line wide enough that the visible column index reaches past 1024;
//   - a few random small rasters.
// Because counters are never cleared by a register write, shrinking the raster
// leaves them past the new totals, and the wrap on the next pixel is checked too.
//
// The sender works in bursts with random gaps and the receiver stalls on a pattern
// of its own. Once during the run the receiver holds off for a long stretch while
// pixels keep coming, so both stages fill and the block stalls its input.

module testbench;
  import rstg_pkg::*;

  // Build-time choices of the block under test.
  localparam int unsigned SYNC_STYLE  = SYNC_STYLE_DEF;
  localparam bit          HSYNC_HIGH  = HSYNC_ACTIVE_HIGH_DEF;
  localparam bit          VSYNC_HIGH  = VSYNC_ACTIVE_HIGH_DEF;
  // Cycles to let pass after the last expected result; the block has two stages.
  localparam int unsigned SETTLE_CYC  = 6;

  // Predicts the timing outputs for every accepted pixel and checks the results
  // in order of arrival.
  class raster_tracker;
    logic [LEN_W-1:0] len_q [8];
    int unsigned      col_q;
    int unsigned      row_q;
    out_item_t        expected_q [$];
    int unsigned      mismatches;
    int unsigned      accepted;

    function new();
      len_q[REG_H_SYNC]    = H_SYNC_RST;
      len_q[REG_H_BACK]    = H_BACK_RST;
      len_q[REG_H_VISIBLE] = H_VISIBLE_RST;
      len_q[REG_H_FRONT]   = H_FRONT_RST;
      len_q[REG_V_SYNC]    = V_SYNC_RST;
      len_q[REG_V_BACK]    = V_BACK_RST;
      len_q[REG_V_VISIBLE] = V_VISIBLE_RST;
      len_q[REG_V_FRONT]   = V_FRONT_RST;
      col_q      = 0;
      row_q      = 0;
      mismatches = 0;
      accepted   = 0;
    endfunction

    function void set_len(cfg_reg_e idx, logic [LEN_W-1:0] value);
      len_q[idx] = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Works out the result of one pixel and moves the raster position on.
    function void note_pixel(in_item_t px);
      out_item_t   r;
      int unsigned h_start, v_start, h_total, v_total;
      bit          hvis, vvis, vline, hs, vs;
      h_start = len_q[REG_H_SYNC] + len_q[REG_H_BACK];
      v_start = len_q[REG_V_SYNC] + len_q[REG_V_BACK];
      h_total = h_start + len_q[REG_H_VISIBLE] + len_q[REG_H_FRONT];
      v_total = v_start + len_q[REG_V_VISIBLE] + len_q[REG_V_FRONT];
      hvis  = col_q >= h_start && col_q < h_start + len_q[REG_H_VISIBLE];
      vvis  = row_q >= v_start && row_q < v_start + len_q[REG_V_VISIBLE];
      vline = row_q < len_q[REG_V_SYNC];
      hs    = (col_q < len_q[REG_H_SYNC]) ? HSYNC_HIGH : !HSYNC_HIGH;
      vs    = vline ? VSYNC_HIGH : !VSYNC_HIGH;

      r = '0;
      r.vsync_pin = !VSYNC_HIGH;
      case (SYNC_STYLE)
        STYLE_SEPARATE: begin
          r.stream_sync = hs;
          r.vsync_pin   = vs;
        end
        STYLE_COMPOSITE_XOR: r.stream_sync = hs ^ vs;
        STYLE_COMPOSITE_AND: r.stream_sync = hs & vs;
        STYLE_PAL:           r.stream_sync = vline ? VSYNC_HIGH : hs;
        default:             r.stream_sync = 1'b0;
      endcase
      if (hvis && vvis) begin
        r.red_out    = px.red_bit;
        r.green_out  = px.green_bit;
        r.blue_out   = px.blue_bit;
        r.in_visible = 1'b1;
        r.pixel_x    = LEN_W'(col_q - h_start);
        r.pixel_y    = LEN_W'(row_q - v_start);
      end
      r.line_begin  = (col_q == 0);
      r.frame_begin = (col_q == 0) && (row_q == 0);
      expected_q.push_back(r);
      accepted++;

      // A counter past a shrunk total wraps on the next pixel as well.
      col_q = (col_q + 1) % (1 << CNT_W);
      if (col_q >= h_total) begin
        col_q = 0;
        row_q = (row_q + 1) % (1 << CNT_W);
        if (row_q >= v_total) begin
          row_q = 0;
        end
      end
    endfunction

    function void check_field(string name, logic [LEN_W-1:0] exp_v, logic [LEN_W-1:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      check_field("stream_sync", e.stream_sync, got.stream_sync);
      check_field("vsync_pin", e.vsync_pin, got.vsync_pin);
      check_field("red_out", e.red_out, got.red_out);
      check_field("green_out", e.green_out, got.green_out);
      check_field("blue_out", e.blue_out, got.blue_out);
      check_field("in_visible", e.in_visible, got.in_visible);
      check_field("pixel_x", e.pixel_x, got.pixel_x);
      check_field("pixel_y", e.pixel_y, got.pixel_y);
      check_field("line_begin", e.line_begin, got.line_begin);
      check_field("frame_begin", e.frame_begin, got.frame_begin);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  cfg_reg_e             cfg_idx;
  logic [LEN_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;

  raster_tracker tracker;

  // The sender's burst state lives across phases so that bursts span phase edges.
  int unsigned burst_left = 0;

  raster_sync_timing_generator_top #(
    .SYNC_STYLE        (SYNC_STYLE),
    .HSYNC_ACTIVE_HIGH (HSYNC_HIGH),
    .VSYNC_ACTIVE_HIGH (VSYNC_HIGH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Every result request accepted at a rising edge is checked right away. The
  // outputs are read before the block's registers update at that edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      tracker.check_pixel(out_data);
    end
  end

  // Receiver: stretches of random length, each with its own stall density. Once,
  // after a few hundred pixels, it holds off long enough for the block to fill up
  // while the sender keeps offering requests.
  initial begin
    int unsigned hold_left;
    int unsigned stretch_left;
    int unsigned density;
    bit          held_once;
    hold_left    = 0;
    stretch_left = 0;
    density      = 0;
    held_once    = 1'b0;
    out_stall    = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held_once && tracker.accepted >= 700) begin
        held_once = 1'b1;
        hold_left = 80;
        out_stall <= 1'b1;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(5, 40);
          density      = $urandom_range(0, 3);
        end
        stretch_left--;
        // Density 0 never stalls; density 3 stalls with a probability of 3/4.
        out_stall <= ($urandom_range(0, 3) < density);
      end
    end
  end

  // Offers one pixel request from a falling edge and holds it until it is taken.
  // Returns at the falling edge after the accepting edge, with valid still high.
  task automatic drive_pixel(input in_item_t px);
    in_valid <= 1'b1;
    in_data  <= px;
    do begin
      @(posedge clk_i);
    end while (in_stall);
    tracker.note_pixel(px);
    @(negedge clk_i);
  endtask

  // Drops valid and waits until every expected result has arrived and the block
  // has had time to settle, so registers can be written safely.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  // Writes all eight lengths, one per cycle, and mirrors them in the predictor.
  task automatic write_timing(input timing_cfg_t t);
    logic [LEN_W-1:0] vals [8];
    vals[REG_H_SYNC]    = t.h_sync_len;
    vals[REG_H_BACK]    = t.h_back_len;
    vals[REG_H_VISIBLE] = t.h_visible_len;
    vals[REG_H_FRONT]   = t.h_front_len;
    vals[REG_V_SYNC]    = t.v_sync_len;
    vals[REG_V_BACK]    = t.v_back_len;
    vals[REG_V_VISIBLE] = t.v_visible_len;
    vals[REG_V_FRONT]   = t.v_front_len;
    wait_idle();
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= cfg_reg_e'(i);
      cfg_data <= vals[i];
      @(posedge clk_i);
      tracker.set_len(cfg_reg_e'(i), vals[i]);
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // Random pixels in bursts. A quarter of the bursts start without a gap, so long
  // stretches of back-to-back requests occur as well.
  task automatic send_random(input int unsigned count);
    int unsigned gap;
    for (int unsigned n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      burst_left--;
      drive_pixel(in_item_t'($urandom_range(0, 7)));
    end
  endtask

  task automatic random_small_raster();
    timing_cfg_t t;
    t.h_sync_len    = $urandom_range(0, 4);
    t.h_back_len    = $urandom_range(0, 4);
    t.h_visible_len = $urandom_range(0, 6);
    t.h_front_len   = $urandom_range(0, 4);
    t.v_sync_len    = $urandom_range(0, 3);
    t.v_back_len    = $urandom_range(0, 3);
    t.v_visible_len = $urandom_range(0, 5);
    t.v_front_len   = $urandom_range(0, 3);
    write_timing(t);
    send_random(80);
  endtask

  initial begin
    timing_cfg_t t;
    tracker  = new();
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = REG_H_SYNC;
    cfg_data = '0;
    rst_ni   = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset timing: the first pixel starts a frame and sits inside hsync.
    for (int i = 0; i < 4; i++) begin
      drive_pixel(in_item_t'(7 - i));
    end

    // Tiny raster with the visible area right after sync: every colour passes
    // through visible pixels and through blanked ones. The counters carry on from
    // where the reset timing left them, so the first line starts mid-way.
    t = '{11'd1, 11'd0, 11'd4, 11'd1, 11'd1, 11'd0, 11'd2, 11'd1};
    write_timing(t);
    for (int i = 0; i < 20; i++) begin
      drive_pixel(in_item_t'(i % 8));
    end
    send_random(250);

    // Empty porches: one sync pixel and one visible pixel per line.
    t = '{11'd1, 11'd0, 11'd1, 11'd0, 11'd1, 11'd0, 11'd1, 11'd0};
    write_timing(t);
    send_random(120);

    // Every length zero: the line total is zero and every pixel begins a frame.
    t = '0;
    write_timing(t);
    send_random(40);

    // Every length at its largest value: the whole run stays in sync and porches.
    t = '{default: '1};
    write_timing(t);
    send_random(150);

    // A wide line, so the visible column index gets past its upper bits.
    t = '{11'd1, 11'd0, 11'd1030, 11'd0, 11'd1, 11'd0, 11'd2, 11'd0};
    write_timing(t);
    send_random(1100);

    repeat (3) random_small_raster();

    wait_idle();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("raster_sync_timing_generator_top test passed");
    end else begin
      $display("raster_sync_timing_generator_top test failed");
    end
    $finish;
  end

  // The whole run needs well under a quarter of a millisecond.
  initial begin
    #2_000_000;
    $display("raster_sync_timing_generator_top test failed");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rstg_pkg.sv
hdl/rstg_cfg.sv
hdl/rstg_position.sv
hdl/rstg_decode.sv
hdl/raster_sync_timing_generator_top.sv
verif/testbench.sv
